@@ hdl/pfd_pkg.sv @@
// Package for the filtered-derivative PID core: widths, register indexes,
// the shared configuration and term-stage structs, and the saturation helper.
// No dependencies.
package pfd_pkg;

  localparam int unsigned MEAS_W     = 16;  // unsigned Q8.8 sample
  localparam int unsigned ERR_W      = 17;  // signed Q9.8 error
  localparam int unsigned ACC_W      = 32;  // gains, terms, limits, output
  localparam int unsigned POLE_W     = 18;  // derivative pole, 16 fraction bits
  localparam int unsigned POLE_FRAC  = 16;
  localparam int unsigned ERR_SHIFT  = 8;   // drop the error's fraction bits
  localparam int unsigned WIDE_W     = 50;  // widest product or sum before saturation
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_PROP_GAIN  = 3'd1,
    CFG_INT_GAIN   = 3'd2,
    CFG_DERIV_GAIN = 3'd3,
    CFG_DERIV_POLE = 3'd4,
    CFG_OUT_MAX    = 3'd5,
    CFG_OUT_MIN    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        [MEAS_W-1:0] setpoint;
    logic signed [ACC_W-1:0]  prop_gain;
    logic signed [ACC_W-1:0]  int_gain;
    logic signed [ACC_W-1:0]  deriv_gain;
    logic signed [POLE_W-1:0] deriv_pole;
    logic signed [ACC_W-1:0]  out_max;
    logic signed [ACC_W-1:0]  out_min;
  } cfg_t;

  // Term stage: products that do not depend on the integrator or the filter.
  typedef struct packed {
    logic                    valid;
    logic                    restart;
    logic signed [ACC_W-1:0] p;
    logic signed [ACC_W-1:0] iterm;
    logic signed [ACC_W-1:0] dterm;
  } term_t;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] acc_hi;
    logic signed [WIDE_W-1:0] acc_lo;
    acc_hi = {{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    acc_lo = {{(WIDE_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
    if (v > acc_hi) begin
      return acc_hi[ACC_W-1:0];
    end else if (v < acc_lo) begin
      return acc_lo[ACC_W-1:0];
    end else begin
      return v[ACC_W-1:0];
    end
  endfunction

endpackage

@@ hdl/pfd_cfg_regs.sv @@
// Configuration register file of the filtered-derivative PID core.
// Depends on pfd_pkg.
module pfd_cfg_regs #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output pfd_pkg::cfg_t                    cfg_o
);

  // Default limits are +/-40.0 in the output format.
  localparam logic signed [pfd_pkg::ACC_W-1:0] OutMaxRst =
    pfd_pkg::ACC_W'(64'sd40 <<< FRACTION_BITS);
  localparam logic signed [pfd_pkg::ACC_W-1:0] OutMinRst = -OutMaxRst;

  localparam pfd_pkg::cfg_t CfgRst = '{
    setpoint:   '0,
    prop_gain:  '0,
    int_gain:   '0,
    deriv_gain: '0,
    deriv_pole: '0,
    out_max:    OutMaxRst,
    out_min:    OutMinRst
  };

  pfd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfd_pkg::CFG_SETPOINT:   cfg_d.setpoint   = cfg_data_i[pfd_pkg::MEAS_W-1:0];
        pfd_pkg::CFG_PROP_GAIN:  cfg_d.prop_gain  = cfg_data_i[pfd_pkg::ACC_W-1:0];
        pfd_pkg::CFG_INT_GAIN:   cfg_d.int_gain   = cfg_data_i[pfd_pkg::ACC_W-1:0];
        pfd_pkg::CFG_DERIV_GAIN: cfg_d.deriv_gain = cfg_data_i[pfd_pkg::ACC_W-1:0];
        pfd_pkg::CFG_DERIV_POLE: cfg_d.deriv_pole = cfg_data_i[pfd_pkg::POLE_W-1:0];
        pfd_pkg::CFG_OUT_MAX:    cfg_d.out_max    = cfg_data_i[pfd_pkg::ACC_W-1:0];
        pfd_pkg::CFG_OUT_MIN:    cfg_d.out_min    = cfg_data_i[pfd_pkg::ACC_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/pfd_terms.sv @@
// Input register and term stage: error, previous error and the three
// error products. Depends on pfd_pkg.
module pfd_terms (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfd_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfd_pkg::MEAS_W-1:0]    meas_i,
  input  logic                          restart_i,
  input  logic                          term_ready_i,
  output pfd_pkg::term_t                term_o
);

  logic                             in_v_q;
  logic [pfd_pkg::MEAS_W-1:0]       meas_q;
  logic                             rst_q;
  logic signed [pfd_pkg::ERR_W-1:0] prev_q;
  pfd_pkg::term_t                   term_q, term_d;

  logic term_free, in_free, term_load;
  logic signed [pfd_pkg::ERR_W-1:0]  err, prev_use;
  logic signed [pfd_pkg::ERR_W:0]    err_sum, err_diff;
  logic signed [pfd_pkg::WIDE_W-1:0] p_prod, i_prod, d_prod;

  assign term_free  = !term_q.valid || term_ready_i;
  assign in_free    = !in_v_q || term_free;
  assign term_load  = in_v_q && term_free;
  assign in_ready_o = in_free;

  assign err      = $signed({1'b0, cfg_i.setpoint}) - $signed({1'b0, meas_q});
  assign prev_use = rst_q ? '0 : prev_q;
  assign err_sum  = (pfd_pkg::ERR_W+1)'(err) + (pfd_pkg::ERR_W+1)'(prev_use);
  assign err_diff = (pfd_pkg::ERR_W+1)'(err) - (pfd_pkg::ERR_W+1)'(prev_use);

  assign p_prod = pfd_pkg::WIDE_W'(cfg_i.prop_gain)  * pfd_pkg::WIDE_W'(err);
  assign i_prod = pfd_pkg::WIDE_W'(cfg_i.int_gain)   * pfd_pkg::WIDE_W'(err_sum);
  assign d_prod = pfd_pkg::WIDE_W'(cfg_i.deriv_gain) * pfd_pkg::WIDE_W'(err_diff);

  // Advance the valid when the stage frees up; load the payload with an item.
  always_comb begin
    term_d = term_q;
    if (term_free) begin
      term_d.valid = in_v_q;
    end
    if (term_load) begin
      term_d.restart = rst_q;
      term_d.p       = pfd_pkg::sat_acc(p_prod >>> pfd_pkg::ERR_SHIFT);
      term_d.iterm   = pfd_pkg::sat_acc(i_prod >>> pfd_pkg::ERR_SHIFT);
      term_d.dterm   = pfd_pkg::sat_acc(d_prod >>> pfd_pkg::ERR_SHIFT);
    end
  end

  // Control and state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      term_q <= '0;
      prev_q <= '0;
    end else begin
      if (in_free) begin
        in_v_q <= in_valid_i;
      end
      term_q <= term_d;
      if (term_load) begin
        prev_q <= err;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_free) begin
      meas_q <= meas_i;
      rst_q  <= restart_i;
    end
  end

  assign term_o = term_q;

endmodule

@@ hdl/pfd_update.sv @@
// Recurrence stage: filtered derivative, clamped integrator and the result
// register. Depends on pfd_pkg.
module pfd_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfd_pkg::cfg_t                 cfg_i,
  input  pfd_pkg::term_t                term_i,
  output logic                          term_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [pfd_pkg::ACC_W-1:0] control_o,
  output logic                          clamped_o
);

  logic                             out_v_q;
  logic signed [pfd_pkg::ACC_W-1:0] integ_q, integ_d;
  logic signed [pfd_pkg::ACC_W-1:0] fd_q, fd_d;
  logic signed [pfd_pkg::ACC_W-1:0] ctrl_q, ctrl_d;
  logic                             clamp_q, clamp_d;

  logic out_free, adv;
  logic signed [pfd_pkg::ACC_W-1:0]  integ_base, fd_base, d_pole, integ_raw, hi, lo;
  logic signed [pfd_pkg::WIDE_W-1:0] pole_prod;

  assign out_free     = !out_v_q || out_ready_i;
  assign adv          = term_i.valid && out_free;
  assign term_ready_o = out_free;

  // Restart clears the state before this step uses it.
  assign integ_base = term_i.restart ? '0 : integ_q;
  assign fd_base    = term_i.restart ? '0 : fd_q;

  assign pole_prod = pfd_pkg::WIDE_W'(cfg_i.deriv_pole) * pfd_pkg::WIDE_W'(fd_base);
  assign d_pole    = pfd_pkg::sat_acc(pole_prod >>> pfd_pkg::POLE_FRAC);
  assign fd_d      = pfd_pkg::sat_acc(pfd_pkg::WIDE_W'(term_i.dterm)
                                      + pfd_pkg::WIDE_W'(d_pole));
  assign integ_raw = pfd_pkg::sat_acc(pfd_pkg::WIDE_W'(integ_base)
                                      + pfd_pkg::WIDE_W'(term_i.iterm));
  assign hi = pfd_pkg::sat_acc(pfd_pkg::WIDE_W'(cfg_i.out_max) - pfd_pkg::WIDE_W'(term_i.p)
                               - pfd_pkg::WIDE_W'(fd_d));
  assign lo = pfd_pkg::sat_acc(pfd_pkg::WIDE_W'(cfg_i.out_min) - pfd_pkg::WIDE_W'(term_i.p)
                               - pfd_pkg::WIDE_W'(fd_d));

  // Upper bound first, lower bound last so it wins when the limits cross.
  always_comb begin
    integ_d = integ_raw;
    clamp_d = 1'b0;
    if (integ_d > hi) begin
      integ_d = hi;
      clamp_d = 1'b1;
    end
    if (integ_d < lo) begin
      integ_d = lo;
      clamp_d = 1'b1;
    end
    ctrl_d = pfd_pkg::sat_acc(pfd_pkg::WIDE_W'(term_i.p) + pfd_pkg::WIDE_W'(integ_d)
                              + pfd_pkg::WIDE_W'(fd_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      integ_q <= '0;
      fd_q    <= '0;
    end else begin
      if (out_free) begin
        out_v_q <= term_i.valid;
      end
      if (adv) begin
        integ_q <= integ_d;
        fd_q    <= fd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q  <= ctrl_d;
      clamp_q <= clamp_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign control_o   = ctrl_q;
  assign clamped_o   = clamp_q;

`ifndef NO_ASSERTIONS
  // A restart step with no derivative drive leaves the filter at zero.
  a_restart_clears_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && term_i.restart && (term_i.dterm == '0)) |=> (fd_q == '0))
    else $error("filter state not cleared by restart");
`endif

endmodule

@@ hdl/pid_filtered_derivative_core.sv @@
// Top level of the PID core with trapezoidal integrator and filtered
// derivative. Depends on pfd_pkg, pfd_cfg_regs, pfd_terms and pfd_update.
//
//  channel   dir  tdata                      tuser
//  s_axis    in   [15:0] measurement          [0] restart
//  m_axis    out  [31:0] control_out          [0] integrator_clamped
//  cfg       in   cfg_we_i, cfg_idx_i (3 b), cfg_data_i (32 b)
//
// Three registers per item: input register, term register (error products),
// result register (filter, integrator, clamp). An accepted item passes the input
// and term registers before its result valid rises in the result register.
// One item per cycle sustained while m_axis_tready stays high; the recurrence
// through the integrator and the derivative filter closes in the last stage.
// Reset clears the pipeline valids, the integrator, the filter, the previous
// error and the registers (limits go to +/-40.0).
// A stalled result holds its stage; up to two more items fill the earlier
// stages before s_axis_tready drops.
module pid_filtered_derivative_core #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // measurement stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [15:0] measurement
  input  logic [0:0]                      s_axis_tuser,   // [0] restart
  // control stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,   // [31:0] control_out
  output logic [0:0]                      m_axis_tuser    // [0] integrator_clamped
);

  pfd_pkg::cfg_t  cfg;
  pfd_pkg::term_t term;
  logic           term_ready;
  logic signed [pfd_pkg::ACC_W-1:0] control;
  logic           clamped;

  pfd_cfg_regs #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register and error products.
  pfd_terms u_terms (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .meas_i       (s_axis_tdata[pfd_pkg::MEAS_W-1:0]),
    .restart_i    (s_axis_tuser[0]),
    .term_ready_i (term_ready),
    .term_o       (term)
  );

  // Filter, integrator clamp and result register.
  pfd_update u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .term_i       (term),
    .term_ready_o (term_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .control_o    (control),
    .clamped_o    (clamped)
  );

  assign m_axis_tdata = control;
  assign m_axis_tuser = clamped;

`ifndef NO_ASSERTIONS
  // A free result stage frees the whole pipeline.
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while result stage is free");

  // A result appears only after the term stage held an item.
  a_result_from_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(term.valid))
    else $error("result without a term-stage item");

  // An idle pipeline always takes input.
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!term.valid && !m_axis_tvalid) |-> s_axis_tready)
    else $error("idle pipeline not ready");
`endif

endmodule

@@ tb/sv/pfd_result_checker.sv @@
// Result checker for the filtered-derivative PID core: predicts each control
// transfer from the measurement stream and the register writes, and compares.
// Depends on pfd_pkg.
module pfd_result_checker #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] measurement
  input  logic [0:0]                        s_axis_tuser,   // [0] restart
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [31:0]                       m_axis_tdata,   // [31:0] control_out
  input  logic [0:0]                        m_axis_tuser,   // [0] integrator_clamped
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [pfd_pkg::ACC_W-1:0] control_out;
    logic                             clamped;
  } pid_result_t;

  // register copies and loop state, held as wide signed values
  longint setpoint_q, kp_q, ki_q, kd_q, pole_q, out_max_q, out_min_q;
  longint integ_q, deriv_q, last_err_q;

  pid_result_t ctl_expected[$];
  int          reported;

  function automatic longint clip_acc(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // Advance the controller by one sample; >>> on longint floors.
  function automatic pid_result_t advance_pid(input logic [pfd_pkg::MEAS_W-1:0] meas,
                                              input logic restart);
    longint      err, p, term, decay, hi, lo;
    pid_result_t res;
    res.clamped = 1'b0;
    if (restart) begin
      integ_q    = 0;
      deriv_q    = 0;
      last_err_q = 0;
    end
    err  = setpoint_q - longint'(meas);
    p    = clip_acc((kp_q * err) >>> pfd_pkg::ERR_SHIFT);
    term = clip_acc((ki_q * (err + last_err_q)) >>> pfd_pkg::ERR_SHIFT);
    integ_q = clip_acc(integ_q + term);
    term  = clip_acc((kd_q * (err - last_err_q)) >>> pfd_pkg::ERR_SHIFT);
    decay = clip_acc((pole_q * deriv_q) >>> pfd_pkg::POLE_FRAC);
    deriv_q    = clip_acc(term + decay);
    last_err_q = err;
    // upper bound first, lower bound last so it wins when the limits cross
    hi = clip_acc(out_max_q - p - deriv_q);
    lo = clip_acc(out_min_q - p - deriv_q);
    if (integ_q > hi) begin
      integ_q     = hi;
      res.clamped = 1'b1;
    end
    if (integ_q < lo) begin
      integ_q     = lo;
      res.clamped = 1'b1;
    end
    res.control_out = pfd_pkg::ACC_W'(clip_acc(p + integ_q + deriv_q));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pid_result_t got, want;
    if (!rst_ni) begin
      setpoint_q   = 0;
      kp_q         = 0;
      ki_q         = 0;
      kd_q         = 0;
      pole_q       = 0;
      out_max_q    = clip_acc(longint'(40) <<< FRACTION_BITS);
      out_min_q    = -out_max_q;
      integ_q      = 0;
      deriv_q      = 0;
      last_err_q   = 0;
      fail_count_o = 0;
      reported     = 0;
      ctl_expected.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser[0]};
        if (ctl_expected.size() == 0) begin
          fail_count_o++;
          if (reported < 10) begin
            $display("%t: control transfer with nothing outstanding: %0d/%0b",
                     $realtime, $signed(got.control_out), got.clamped);
          end
          reported++;
        end else begin
          want = ctl_expected.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (reported < 10) begin
              $display("%t: mismatch control_out exp %0d got %0d, clamped exp %0b got %0b",
                       $realtime, $signed(want.control_out), $signed(got.control_out),
                       want.clamped, got.clamped);
            end
            reported++;
          end
        end
      end
      if (cfg_we_i) begin
        case (pfd_pkg::cfg_idx_e'(cfg_idx_i))
          pfd_pkg::CFG_SETPOINT:
            setpoint_q = longint'(cfg_data_i[pfd_pkg::MEAS_W-1:0]);
          pfd_pkg::CFG_PROP_GAIN:  kp_q      = longint'($signed(cfg_data_i));
          pfd_pkg::CFG_INT_GAIN:   ki_q      = longint'($signed(cfg_data_i));
          pfd_pkg::CFG_DERIV_GAIN: kd_q      = longint'($signed(cfg_data_i));
          pfd_pkg::CFG_DERIV_POLE:
            pole_q = longint'($signed(cfg_data_i[pfd_pkg::POLE_W-1:0]));
          pfd_pkg::CFG_OUT_MAX:    out_max_q = longint'($signed(cfg_data_i));
          pfd_pkg::CFG_OUT_MIN:    out_min_q = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ctl_expected.push_back(advance_pid(s_axis_tdata, s_axis_tuser[0]));
      end
    end
    pending_o = ctl_expected.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the PID core testbench: clock, reset, register writes, measurement
// stimulus and the verdict. Depends on pfd_pkg, pfd_result_checker and the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int BLOCKS         = 25;
  localparam int BLOCK_ITEMS    = 50;

  // index 7 has no register behind it; writes there must change nothing
  localparam logic [pfd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam logic [31:0] Q_ONE    = 32'h0001_0000;
  localparam logic [31:0] LIMIT_40 = 32'd2621440;
  localparam logic [31:0] ACC_HI   = 32'h7FFF_FFFF;
  localparam logic [31:0] ACC_LO   = 32'h8000_0000;
  localparam logic [31:0] POLE_HI  = 32'h0001_0000;   // +1.0
  localparam logic [31:0] POLE_LO  = 32'hFFFF_0000;   // -1.0

  // every block input starts at a known value
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [15:0]                    s_axis_tdata  = '0;
  logic [0:0]                     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;
  logic [0:0]                     m_axis_tuser;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 22;
  int          recv_idle_pct = 87;
  int          idle_cycles   = 0;
  logic [15:0] cur_setpoint  = '0;

  pid_filtered_derivative_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pfd_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Receiver: decide readiness once per cycle at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run once nothing has been transferred for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // One register write; the block takes it at the rising edge in between.
  task automatic write_reg(input logic [pfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Write every register, in index order. Call only while the block is idle.
  task automatic load_config(input logic [15:0] sp, input logic [31:0] kp,
                             input logic [31:0] ki, input logic [31:0] kd,
                             input logic [31:0] pole, input logic [31:0] hi,
                             input logic [31:0] lo);
    write_reg(pfd_pkg::CFG_SETPOINT, {16'b0, sp});
    write_reg(pfd_pkg::CFG_PROP_GAIN, kp);
    write_reg(pfd_pkg::CFG_INT_GAIN, ki);
    write_reg(pfd_pkg::CFG_DERIV_GAIN, kd);
    write_reg(pfd_pkg::CFG_DERIV_POLE, pole);
    write_reg(pfd_pkg::CFG_OUT_MAX, hi);
    write_reg(pfd_pkg::CFG_OUT_MIN, lo);
    cur_setpoint = sp;
  endtask

  // Offer one measurement, idling first at random; return after the transfer.
  // Valid stays high into the next call so back-to-back items leave no bubble.
  task automatic push_sample(input logic [15:0] meas, input logic restart);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= meas;
    s_axis_tuser[0] <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and hold off until every outstanding result has arrived
  // and the three-stage pipeline has emptied.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Gains: mostly moderate, sometimes zero, full scale or fully random.
  function automatic logic [31:0] rand_gain(input int unsigned span);
    case ($urandom_range(9))
      0: return '0;
      1: return ACC_HI;
      2: return ACC_LO;
      3: return $urandom();
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic logic [31:0] rand_pole();
    case ($urandom_range(7))
      0: return POLE_LO;
      1: return POLE_HI;
      2: return '0;
      default: return $urandom_range(0, 131072) - 32'd65536;
    endcase
  endfunction

  task automatic rand_config();
    logic [31:0] a, b, hi, lo;
    a = $urandom();
    b = $urandom();
    case ($urandom_range(5))
      0: begin
        hi = LIMIT_40;
        lo = -LIMIT_40;
      end
      1: begin
        // random ordered pair
        hi = ($signed(a) > $signed(b)) ? a : b;
        lo = ($signed(a) > $signed(b)) ? b : a;
      end
      2: begin
        // crossed limits: the lower bound wins
        hi = -($urandom_range(1, 100) << 16);
        lo = $urandom_range(1, 100) << 16;
      end
      3: begin
        hi = ACC_HI;
        lo = ACC_LO;
      end
      default: begin
        hi = $urandom_range(1, 200) << 16;
        lo = -($urandom_range(1, 200) << 16);
      end
    endcase
    load_config(16'($urandom()), rand_gain(32'h0008_0000), rand_gain(32'h0000_4000),
                rand_gain(32'h0004_0000), rand_pole(), hi, lo);
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_IDX_UNUSED, $urandom());
    end
  endtask

  initial begin : stimulus
    int          track;
    int          delta;
    logic [15:0] meas;
    // hold reset, then release it away from the rising edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers (all gains zero) with extreme samples.
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    settle();

    // Unity P and D gains, default limits: large errors clamp the integrator,
    // restart clears the loop state mid-run.
    load_config(16'h8000, Q_ONE, 32'h0000_4000, Q_ONE, 32'h0000_8000,
                LIMIT_40, -LIMIT_40);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h7F00, 1'b0);
    push_sample(16'h7F00, 1'b0);
    push_sample(16'h8100, 1'b0);
    settle();

    // Full-scale gains and widest limits: the products of large errors saturate.
    load_config(16'hFFFF, ACC_HI, ACC_HI, ACC_LO, POLE_LO, ACC_HI, ACC_LO);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    settle();

    // Crossed limits with the pole at +1.0; the unused index must be ignored.
    load_config(16'h0000, -Q_ONE, Q_ONE, Q_ONE, POLE_HI, -(32'd10 << 16), 32'd10 << 16);
    write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
    push_sample(16'h0100, 1'b0);
    push_sample(16'h0200, 1'b0);
    push_sample(16'h0000, 1'b1);
    push_sample(16'h0300, 1'b0);
    settle();

    // Random blocks, one register setting each; idling changes per third.
    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk < BLOCKS / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 87;
      end else if (blk < 2 * BLOCKS / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      rand_config();
      track = $urandom_range(0, 65535);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        case ($urandom_range(9))
          7, 8: meas = 16'($urandom());
          9:    meas = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: begin
            // settle toward the setpoint with some sensor noise
            delta = (int'(cur_setpoint) - track) / 8 + int'($urandom_range(0, 128)) - 64;
            track = track + delta;
            if (track < 0) track = 0;
            if (track > 65535) track = 65535;
            meas = track[15:0];
          end
        endcase
        push_sample(meas, $urandom_range(19) == 0);
      end
      settle();
    end

    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
